// ----- rtl/scc_pkg.sv -----
// shared constants, codes and state encoding for the scc core
`timescale 1ns / 1ps
package scc_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES    = 64;
  localparam int VW           = 5;   // vertex and component width
  localparam int EAW          = 6;   // edge store address width
  localparam int ECW          = 7;   // edge count width
  localparam int NW           = 6;   // vertex count width
  localparam int SW           = VW + ECW;  // walk stack entry width
  localparam int PAW          = 3;   // config address width

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FIND  = 2'd1,
    OP_LIST  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_MEMBER = 2'd0,
    KIND_REDGE  = 2'd1,
    KIND_NONE   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic [NW-1:0] VERTEX_COUNT_RESET = 6'd8;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_REJ,
    ST_P1_ROOT,
    ST_P1_SCAN,
    ST_P1_CHECK,
    ST_P1_POP,
    ST_TB,
    ST_TB_CHK,
    ST_P2_ROOT,
    ST_P2_ROOTV,
    ST_P2_SCAN,
    ST_P2_T,
    ST_P2_CHECK,
    ST_P2_POP,
    ST_EM_RD,
    ST_EM_M,
    ST_EM_C,
    ST_EM_OUT,
    ST_L_P,
    ST_L_U,
    ST_L_C,
    ST_L_E,
    ST_L_ECHK,
    ST_L_D,
    ST_L_FLUSH,
    ST_L_END
  } state_t;

  function automatic logic [NW-1:0] eff_count(input logic [NW-1:0] v);
    logic [NW-1:0] r;
    r = v;
    if (v == '0) r = NW'(1);
    if (v > NW'(MAX_VERTICES)) r = NW'(MAX_VERTICES);
    return r;
  endfunction

endpackage

// ----- rtl/scc_if.sv -----
// valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps
interface scc_in_if;
  import scc_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    operation;
  logic [VW-1:0] src_vertex;
  logic [VW-1:0] dst_vertex;
  modport source (output valid, operation, src_vertex, dst_vertex, input ready);
  modport sink (input valid, operation, src_vertex, dst_vertex, output ready);
endinterface

interface scc_out_if;
  import scc_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    kind;
  logic [VW-1:0] component;
  logic [VW-1:0] member_vertex;
  logic [VW-1:0] target_component;
  logic [NW-1:0] component_total;
  logic [NW-1:0] tree_total;
  logic          last;
  modport source (output valid, kind, component, member_vertex, target_component,
                  component_total, tree_total, last, input ready);
  modport sink (input valid, kind, component, member_vertex, target_component,
                component_total, tree_total, last, output ready);
endinterface

// ----- rtl/strongly_connected_components_core.sv -----
// Strongly connected components core (two-pass depth-first search over an edge store).
// Adding or clearing edges is done in the idle state as the command is taken. A find
// command walks the graph with one sequencer and rams that have one write port and one
// registered read port: the first pass looks at the edges from every vertex on the walk,
// then the transposed edge list is built by scanning the stored edges once per vertex,
// the second pass scans the list entries for every vertex on its walk, and then one
// membership beat is sent per covered vertex. A list command scans the stored edges for
// each covered vertex, reads the component of the target of each of its out-edges, and
// sends the reduced edge beats. The input is not ready until the final beat of the
// command has been loaded into the output register.
`timescale 1ns / 1ps
module strongly_connected_components_core import scc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  scc_in_if.sink         in_item,
  scc_out_if.source      out_item,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [NW-1:0] vertex_count, neff;

  scc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .vertex_count
  );

  state_t state, state_next;
  logic [NW-1:0]  n, n_next, r, r_next, i, i_next, sp, sp_next, fin, fin_next;
  logic [NW-1:0]  seq, seq_next, comps, comps_next, trees, trees_next;
  logic [NW-1:0]  covered, covered_next;
  logic [ECW-1:0] es, es_next, tlen, tlen_next, cur, cur_next, e, e_next, k, k_next;
  logic [VW-1:0]  tv, tv_next, u, u_next, c, c_next, tgt, tgt_next;
  logic [VW-1:0]  pc, pc_next, pt, pt_next;
  logic           pend, pend_next;
  logic [MAX_VERTICES-1:0] visit, visit_next;

  logic           ovalid, ovalid_next, olast, olast_next;
  logic [1:0]     okind, okind_next;
  logic [VW-1:0]  ocomp, ocomp_next, omem, omem_next, otgt, otgt_next;
  logic [NW-1:0]  octot, octot_next, ottot, ottot_next;

  logic                  edge_we, tl_we, stk_we, fo_we, cv_we, ms_we;
  logic [EAW-1:0]        edge_waddr, edge_raddr, tl_waddr, tl_raddr;
  logic [2*VW-1:0]       edge_wdata, edge_rdata;
  logic [EAW-1:0]        tl_wdata, tl_rdata;
  logic [VW-1:0]         stk_waddr, stk_raddr, fo_waddr, fo_raddr;
  logic [VW-1:0]         cv_waddr, cv_raddr, ms_waddr, ms_raddr;
  logic [SW-1:0]         stk_wdata, stk_rdata;
  logic [VW-1:0]         fo_wdata, fo_rdata, cv_wdata, cv_rdata, ms_wdata, ms_rdata;

  scc_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk, .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata));
  scc_ram #(.WIDTH(EAW), .DEPTH(MAX_EDGES)) u_tlist_ram (
    .clk, .we(tl_we), .waddr(tl_waddr), .wdata(tl_wdata),
    .raddr(tl_raddr), .rdata(tl_rdata));
  scc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_finish_ram (
    .clk, .we(fo_we), .waddr(fo_waddr), .wdata(fo_wdata),
    .raddr(fo_raddr), .rdata(fo_rdata));
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_comp_ram (
    .clk, .we(cv_we), .waddr(cv_waddr), .wdata(cv_wdata),
    .raddr(cv_raddr), .rdata(cv_rdata));
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_member_ram (
    .clk, .we(ms_we), .waddr(ms_waddr), .wdata(ms_wdata),
    .raddr(ms_raddr), .rdata(ms_rdata));

  logic          acc, out_free;
  logic [VW-1:0] es_src, es_dst;
  logic [NW-1:0] sp_m1, sp_m2, i_m1;
  logic [ECW-1:0] e_m1;

  assign neff     = eff_count(vertex_count);
  assign in_item.ready = (state == ST_IDLE);
  assign acc      = in_item.valid && in_item.ready;
  assign out_free = !ovalid || out_item.ready;
  assign es_src   = edge_rdata[2*VW-1:VW];
  assign es_dst   = edge_rdata[VW-1:0];
  assign sp_m1    = sp - NW'(1);
  assign sp_m2    = sp - NW'(2);
  assign i_m1     = i - NW'(1);
  assign e_m1     = e - ECW'(1);

  assign out_item.valid            = ovalid;
  assign out_item.kind             = okind;
  assign out_item.component        = ocomp;
  assign out_item.member_vertex    = omem;
  assign out_item.target_component = otgt;
  assign out_item.component_total  = octot;
  assign out_item.tree_total       = ottot;
  assign out_item.last             = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      es      <= '0;
      comps   <= '0;
      trees   <= '0;
      covered <= '0;
      ovalid  <= 1'b0;
    end else begin
      state   <= state_next;
      es      <= es_next;
      comps   <= comps_next;
      trees   <= trees_next;
      covered <= covered_next;
      ovalid  <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    n <= n_next;  r <= r_next;  i <= i_next;  sp <= sp_next;  fin <= fin_next;
    seq <= seq_next;  tlen <= tlen_next;  cur <= cur_next;  e <= e_next;  k <= k_next;
    tv <= tv_next;  u <= u_next;  c <= c_next;  tgt <= tgt_next;
    pc <= pc_next;  pt <= pt_next;  pend <= pend_next;  visit <= visit_next;
    okind <= okind_next;  ocomp <= ocomp_next;  omem <= omem_next;  otgt <= otgt_next;
    octot <= octot_next;  ottot <= ottot_next;  olast <= olast_next;
  end

  always_comb begin
    state_next = state;
    n_next = n;  r_next = r;  i_next = i;  sp_next = sp;  fin_next = fin;
    seq_next = seq;  comps_next = comps;  trees_next = trees;  covered_next = covered;
    es_next = es;  tlen_next = tlen;  cur_next = cur;  e_next = e;  k_next = k;
    tv_next = tv;  u_next = u;  c_next = c;  tgt_next = tgt;
    pc_next = pc;  pt_next = pt;  pend_next = pend;  visit_next = visit;
    ovalid_next = ovalid && !out_item.ready;
    okind_next = okind;  ocomp_next = ocomp;  omem_next = omem;  otgt_next = otgt;
    octot_next = octot;  ottot_next = ottot;  olast_next = olast;

    edge_we = 1'b0;  edge_waddr = '0;  edge_wdata = '0;  edge_raddr = '0;
    tl_we = 1'b0;  tl_waddr = '0;  tl_wdata = '0;  tl_raddr = '0;
    stk_we = 1'b0;  stk_waddr = '0;  stk_wdata = '0;  stk_raddr = '0;
    fo_we = 1'b0;  fo_waddr = '0;  fo_wdata = '0;  fo_raddr = '0;
    cv_we = 1'b0;  cv_waddr = '0;  cv_wdata = '0;  cv_raddr = '0;
    ms_we = 1'b0;  ms_waddr = '0;  ms_wdata = '0;  ms_raddr = '0;

    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (op_t'(in_item.operation))
            OP_ADD: begin
              if ({1'b0, in_item.src_vertex} >= neff || {1'b0, in_item.dst_vertex} >= neff
                  || es >= ECW'(MAX_EDGES)) begin
                state_next = ST_REJ;
              end else begin
                edge_we    = 1'b1;
                edge_waddr = es[EAW-1:0];
                edge_wdata = {in_item.src_vertex, in_item.dst_vertex};
                es_next    = es + ECW'(1);
              end
            end
            OP_FIND: begin
              n_next = neff;  visit_next = '0;  trees_next = '0;
              r_next = '0;  fin_next = '0;
              state_next = ST_P1_ROOT;
            end
            OP_LIST: begin
              r_next = '0;  k_next = '0;  pend_next = 1'b0;
              state_next = ST_L_P;
            end
            OP_CLEAR: es_next = '0;
            default: ;
          endcase
        end
      end
      ST_REJ: begin
        if (out_free) begin
          ovalid_next = 1'b1;  okind_next = KIND_REJECT;  ocomp_next = '0;
          omem_next = '0;  otgt_next = '0;  octot_next = comps;  ottot_next = trees;
          olast_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      // first pass: post-order walk along out-edges
      ST_P1_ROOT: begin
        if (r == n) begin
          r_next = '0;  e_next = '0;  tlen_next = '0;
          state_next = ST_TB;
        end else if (visit[r[VW-1:0]]) begin
          r_next = r + NW'(1);
        end else begin
          trees_next = trees + NW'(1);
          visit_next[r[VW-1:0]] = 1'b1;
          tv_next = r[VW-1:0];  cur_next = '0;  sp_next = NW'(1);
          state_next = ST_P1_SCAN;
        end
      end
      ST_P1_SCAN: begin
        if (cur < es) begin
          edge_raddr = cur[EAW-1:0];
          cur_next = cur + ECW'(1);
          state_next = ST_P1_CHECK;
        end else begin
          fo_we = 1'b1;  fo_waddr = fin[VW-1:0];  fo_wdata = tv;
          fin_next = fin + NW'(1);
          sp_next = sp_m1;
          if (sp == NW'(1)) begin
            r_next = r + NW'(1);
            state_next = ST_P1_ROOT;
          end else begin
            stk_raddr = sp_m2[VW-1:0];
            state_next = ST_P1_POP;
          end
        end
      end
      ST_P1_CHECK: begin
        if (es_src == tv && {1'b0, es_dst} < n && !visit[es_dst]) begin
          visit_next[es_dst] = 1'b1;
          stk_we = 1'b1;  stk_waddr = sp_m1[VW-1:0];  stk_wdata = {tv, cur};
          tv_next = es_dst;  cur_next = '0;  sp_next = sp + NW'(1);
        end
        state_next = ST_P1_SCAN;
      end
      ST_P1_POP: begin
        tv_next = stk_rdata[SW-1:ECW];
        cur_next = stk_rdata[ECW-1:0];
        state_next = ST_P1_SCAN;
      end
      // transposed edge list, by source then insertion order
      ST_TB: begin
        if (r == n) begin
          visit_next = '0;  comps_next = '0;  seq_next = '0;  i_next = n;
          state_next = ST_P2_ROOT;
        end else if (e == es) begin
          e_next = '0;
          r_next = r + NW'(1);
        end else begin
          edge_raddr = e[EAW-1:0];
          e_next = e + ECW'(1);
          state_next = ST_TB_CHK;
        end
      end
      ST_TB_CHK: begin
        if (es_src == r[VW-1:0] && {1'b0, es_dst} < n) begin
          tl_we = 1'b1;  tl_waddr = tlen[EAW-1:0];  tl_wdata = e_m1[EAW-1:0];
          tlen_next = tlen + ECW'(1);
        end
        state_next = ST_TB;
      end
      // second pass: reverse finish order over the transposed graph
      ST_P2_ROOT: begin
        if (i == '0) begin
          covered_next = n;  r_next = '0;
          state_next = ST_EM_RD;
        end else begin
          fo_raddr = i_m1[VW-1:0];
          i_next = i_m1;
          state_next = ST_P2_ROOTV;
        end
      end
      ST_P2_ROOTV: begin
        if (visit[fo_rdata]) begin
          state_next = ST_P2_ROOT;
        end else begin
          visit_next[fo_rdata] = 1'b1;
          cv_we = 1'b1;  cv_waddr = fo_rdata;  cv_wdata = comps[VW-1:0];
          ms_we = 1'b1;  ms_waddr = seq[VW-1:0];  ms_wdata = fo_rdata;
          seq_next = seq + NW'(1);
          tv_next = fo_rdata;  cur_next = '0;  sp_next = NW'(1);
          state_next = ST_P2_SCAN;
        end
      end
      ST_P2_SCAN: begin
        if (cur < tlen) begin
          tl_raddr = cur[EAW-1:0];
          cur_next = cur + ECW'(1);
          state_next = ST_P2_T;
        end else begin
          sp_next = sp_m1;
          if (sp == NW'(1)) begin
            comps_next = comps + NW'(1);
            state_next = ST_P2_ROOT;
          end else begin
            stk_raddr = sp_m2[VW-1:0];
            state_next = ST_P2_POP;
          end
        end
      end
      ST_P2_T: begin
        edge_raddr = tl_rdata;
        state_next = ST_P2_CHECK;
      end
      ST_P2_CHECK: begin
        if (es_dst == tv && !visit[es_src]) begin
          visit_next[es_src] = 1'b1;
          cv_we = 1'b1;  cv_waddr = es_src;  cv_wdata = comps[VW-1:0];
          ms_we = 1'b1;  ms_waddr = seq[VW-1:0];  ms_wdata = es_src;
          seq_next = seq + NW'(1);
          stk_we = 1'b1;  stk_waddr = sp_m1[VW-1:0];  stk_wdata = {tv, cur};
          tv_next = es_src;  cur_next = '0;  sp_next = sp + NW'(1);
        end
        state_next = ST_P2_SCAN;
      end
      ST_P2_POP: begin
        tv_next = stk_rdata[SW-1:ECW];
        cur_next = stk_rdata[ECW-1:0];
        state_next = ST_P2_SCAN;
      end
      // membership beats
      ST_EM_RD: begin
        if (r == covered) begin
          state_next = ST_IDLE;
        end else begin
          ms_raddr = r[VW-1:0];
          state_next = ST_EM_M;
        end
      end
      ST_EM_M: begin
        u_next = ms_rdata;
        cv_raddr = ms_rdata;
        state_next = ST_EM_C;
      end
      ST_EM_C: begin
        c_next = cv_rdata;
        state_next = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        if (out_free) begin
          ovalid_next = 1'b1;  okind_next = KIND_MEMBER;  ocomp_next = c;
          omem_next = u;  otgt_next = '0;  octot_next = comps;  ottot_next = trees;
          olast_next = (r == covered - NW'(1));
          r_next = r + NW'(1);
          state_next = ST_EM_RD;
        end
      end
      // reduced graph listing, one beat held back to mark the last
      ST_L_P: begin
        if (r == covered) begin
          state_next = ST_L_END;
        end else begin
          ms_raddr = r[VW-1:0];
          state_next = ST_L_U;
        end
      end
      ST_L_U: begin
        u_next = ms_rdata;
        cv_raddr = ms_rdata;
        state_next = ST_L_C;
      end
      ST_L_C: begin
        c_next = cv_rdata;
        e_next = '0;
        state_next = ST_L_E;
      end
      ST_L_E: begin
        if (e == es) begin
          r_next = r + NW'(1);
          state_next = ST_L_P;
        end else begin
          edge_raddr = e[EAW-1:0];
          e_next = e + ECW'(1);
          state_next = ST_L_ECHK;
        end
      end
      ST_L_ECHK: begin
        if (es_src == u && {1'b0, es_dst} < covered) begin
          cv_raddr = es_dst;
          state_next = ST_L_D;
        end else begin
          state_next = ST_L_E;
        end
      end
      ST_L_D: begin
        state_next = ST_L_E;
        if (cv_rdata != c && k < ECW'(MAX_EDGES)) begin
          k_next = k + ECW'(1);
          if (!pend) begin
            pend_next = 1'b1;  pc_next = c;  pt_next = cv_rdata;
          end else begin
            tgt_next = cv_rdata;
            state_next = ST_L_FLUSH;
          end
        end
      end
      ST_L_FLUSH: begin
        if (out_free) begin
          ovalid_next = 1'b1;  okind_next = KIND_REDGE;  ocomp_next = pc;
          omem_next = '0;  otgt_next = pt;  octot_next = comps;  ottot_next = trees;
          olast_next = 1'b0;
          pc_next = c;  pt_next = tgt;
          state_next = ST_L_E;
        end
      end
      ST_L_END: begin
        if (out_free) begin
          ovalid_next = 1'b1;  omem_next = '0;  octot_next = comps;  ottot_next = trees;
          olast_next = 1'b1;
          if (pend) begin
            okind_next = KIND_REDGE;  ocomp_next = pc;  otgt_next = pt;
          end else begin
            okind_next = KIND_NONE;  ocomp_next = '0;  otgt_next = '0;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_stack_depth: assert property (@(posedge clk) disable iff (rst)
    (state == ST_P1_SCAN || state == ST_P2_SCAN) |-> (sp != '0 && sp <= n))
    else $error("walk stack depth out of range");
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    es <= ECW'(MAX_EDGES))
    else $error("edge store overfilled");
  a_find_start: assert property (@(posedge clk) disable iff (rst)
    (acc && in_item.operation == OP_FIND) |=> (visit == '0 && trees == '0))
    else $error("find did not clear marks");
  a_seq_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EM_RD) |-> (seq == n && covered == n && comps <= n))
    else $error("second pass did not cover every vertex");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !out_item.ready) |=> ovalid)
    else $error("result beat dropped");
`endif

endmodule

// ----- rtl/scc_ram.sv -----
// generic single write, single registered read ram
`timescale 1ns / 1ps
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/scc_regs.sv -----
// apb configuration register file
`timescale 1ns / 1ps
module scc_regs import scc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output logic [NW-1:0]  vertex_count
);
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (wr && paddr[2] == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[NW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VERTEX_COUNT) prdata = {{(32-NW){1'b0}}, vertex_count};
  end
endmodule
